@@ rtl/zps_pkg.sv @@
// ----------------------------------------------------------------------------
// zps_pkg
// Shared widths, codes and helpers for the zone priority stream selector.
// ----------------------------------------------------------------------------
package zps_pkg;

	localparam int unsigned ZONE_W      = 4;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned LEN_W       = 11;
	localparam int unsigned PT_W        = 7;
	localparam int unsigned SEQ_W       = 16;
	localparam int unsigned MASK_W      = 16;
	localparam int unsigned PRIO_W      = 4;
	localparam int unsigned PRIOS_W     = 64;
	localparam int unsigned STEP_W      = 16;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 64;

	localparam logic [LEN_W-1:0]  MIN_PACKET_BYTES = 11'd12;
	localparam logic [TIME_W-1:0] RESET_SILENCE    = 32'd1000;
	localparam logic [TIME_W-1:0] RESET_SSRC       = 32'h5A5A_0003;
	localparam logic [STEP_W-1:0] RESET_TS_STEP    = 16'd160;

	typedef enum logic {
		OP_PACKET = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE  = 3'd0,
		CFG_PRIO    = 3'd1,
		CFG_SILENCE = 3'd2,
		CFG_SSRC    = 3'd3,
		CFG_TS_STEP = 3'd4
	} cfg_idx_t;

	// what the beat in flight through the memory read stage is for
	typedef enum logic [1:0] {
		TAG_NONE = 2'd0,
		TAG_INIT = 2'd1,
		TAG_CAND = 2'd2,
		TAG_SIL  = 2'd3
	} tag_kind_t;

	function automatic logic [PRIO_W-1:0] prio_of(input logic [PRIOS_W-1:0] prios,
			input logic [ZONE_W-1:0] zone);
		prio_of = prios[zone*PRIO_W +: PRIO_W];
	endfunction

endpackage

@@ rtl/zps_if.sv @@
// ----------------------------------------------------------------------------
// zps_if
// Channel interfaces: input item, result item and configuration write.
// ----------------------------------------------------------------------------
interface zps_item_if import zps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [ZONE_W-1:0] zone_index;
	logic [TIME_W-1:0] now_ms;
	logic [LEN_W-1:0]  packet_length;
	logic [PT_W-1:0]   payload_type;

	modport source (output valid, op, zone_index, now_ms, packet_length, payload_type,
		input ready);
	modport sink (input valid, op, zone_index, now_ms, packet_length, payload_type,
		output ready);
endinterface

interface zps_result_if import zps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              forward;
	logic              marker;
	logic [PT_W-1:0]   out_payload_type;
	logic [SEQ_W-1:0]  sequence_number;
	logic [TIME_W-1:0] rtp_timestamp;
	logic              winner_valid;
	logic [ZONE_W-1:0] winner_zone;
	logic [MASK_W-1:0] released_mask;

	modport source (output valid, forward, marker, out_payload_type, sequence_number,
		rtp_timestamp, winner_valid, winner_zone, released_mask, input ready);
	modport sink (input valid, forward, marker, out_payload_type, sequence_number,
		rtp_timestamp, winner_valid, winner_zone, released_mask, output ready);
endinterface

interface zps_cfg_if import zps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/zps_zone_mem.sv @@
// ----------------------------------------------------------------------------
// zps_zone_mem
// Per-zone time stamps: last heard and first heard, one read port each sharing
// one address, registered read data, one write port.
// ----------------------------------------------------------------------------
module zps_zone_mem import zps_pkg::*; #(
	parameter int unsigned ZONE_COUNT = 16,
	parameter int unsigned AW         = 4
) (
	input  logic              clk,
	input  logic              wr_last_en,
	input  logic              wr_first_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [TIME_W-1:0] wr_data,
	input  logic [AW-1:0]     rd_addr,
	output logic [TIME_W-1:0] rd_last,
	output logic [TIME_W-1:0] rd_first
);

	logic [TIME_W-1:0] last_mem  [ZONE_COUNT];
	logic [TIME_W-1:0] first_mem [ZONE_COUNT];

	always_ff @(posedge clk) begin
		if (wr_last_en) begin
			last_mem[wr_addr] <= wr_data;
		end
		if (wr_first_en) begin
			first_mem[wr_addr] <= wr_data;
		end
		rd_last  <= last_mem[rd_addr];
		rd_first <= first_mem[rd_addr];
	end

endmodule

@@ rtl/zone_priority_stream_selector.sv @@
// ----------------------------------------------------------------------------
// zone_priority_stream_selector
// Picks the audio zone to forward and rewrites the RTP sequence and timestamp.
// ----------------------------------------------------------------------------
// Channels: items (packet arrival or time tick), results (one beat per item),
// cfg (register writes, always ready; write only while the block is idle).
// Per-zone last-heard and first-heard times live in a small synchronous
// memory; the active flags, winner and RTP counters are in flops.
// An item is handled one at a time. A packet that counts (enabled zone in
// range, 12 bytes or more) goes from accept to the result register through
// one read of the winner's first-heard time, a selection pass over all
// zones, a drain step, a decision step, then the silence pass over all zones
// and its drain; each pass reads one memory entry per cycle. Any other item
// skips the selection and goes straight to the silence pass. items.ready is
// high only in the idle state, entered once the result is loaded.
// The result sits in an output register, so the next item is accepted while
// it waits; if results.ready stays low the block finishes that next item and
// then holds until the register frees up.
// Reset clears all zones, the winner, the counters and the output valid, and
// restores the register defaults. The memory needs no clearing: an entry is
// only used while its zone is active, and activation writes it.
// ----------------------------------------------------------------------------
module zone_priority_stream_selector import zps_pkg::*; #(
	parameter int unsigned ZONE_COUNT = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	zps_cfg_if.sink       cfg,
	zps_item_if.sink      items,
	zps_result_if.source  results
);

	localparam int unsigned ZW = $clog2(ZONE_COUNT);
	localparam logic [ZW-1:0] LAST_ZONE = ZW'(ZONE_COUNT - 1);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_LOAD   = 8'b0000_0010,
		ST_SEL    = 8'b0000_0100,
		ST_SDRAIN = 8'b0000_1000,
		ST_DECIDE = 8'b0001_0000,
		ST_SIL    = 8'b0010_0000,
		ST_LDRAIN = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [ZW-1:0] cnt_q;

	// configuration
	logic [MASK_W-1:0]  enable_q;
	logic [PRIOS_W-1:0] prios_q;
	logic [TIME_W-1:0]  silence_q;
	logic [TIME_W-1:0]  ssrc_q;
	logic [STEP_W-1:0]  ts_step_q;

	// block state
	logic [ZONE_COUNT-1:0] active_q;
	logic [ZONE_W-1:0]     cur_zone_q;
	logic                  cur_valid_q;
	logic [SEQ_W-1:0]      next_seq_q;
	logic [TIME_W-1:0]     next_ts_q;

	// item being worked on
	logic [ZONE_W-1:0] zi_q;
	logic [TIME_W-1:0] now_q;
	logic [PT_W-1:0]   pt_q;

	// selection
	logic              have_q;
	logic [ZONE_W-1:0] win_q;
	logic [TIME_W-1:0] win_first_q;

	// result being built
	logic                  fwd_q;
	logic                  mark_q;
	logic [PT_W-1:0]       opt_q;
	logic [SEQ_W-1:0]      seq_q;
	logic [TIME_W-1:0]     ts_q;
	logic [ZONE_COUNT-1:0] released_q;

	// read stage
	tag_kind_t         tag_kind_s1;
	logic [ZW-1:0]     tag_zone_s1;
	tag_kind_t         tag_kind;
	logic [ZW-1:0]     rd_addr;
	logic [TIME_W-1:0] rd_last;
	logic [TIME_W-1:0] rd_first;

	// output register
	logic              out_valid_q;
	logic              out_fwd_q;
	logic              out_mark_q;
	logic [PT_W-1:0]   out_pt_q;
	logic [SEQ_W-1:0]  out_seq_q;
	logic [TIME_W-1:0] out_ts_q;
	logic              out_wv_q;
	logic [ZONE_W-1:0] out_wz_q;
	logic [MASK_W-1:0] out_rel_q;

	logic in_acc;
	logic cfg_acc;
	logic pkt_ok;
	logic wr_first_en;
	logic out_load;

	logic [ZONE_W-1:0] cand_zone;
	logic [PRIO_W-1:0] cand_prio;
	logic [PRIO_W-1:0] win_prio;
	logic [TIME_W-1:0] first_diff;
	logic              cand_better;
	logic              silent;

	assign items.ready = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign in_acc      = items.valid && items.ready;
	assign cfg_acc     = cfg.valid && cfg.ready;

	assign pkt_ok = (items.op == OP_PACKET)
		&& ({1'b0, items.zone_index} < (ZONE_W+1)'(ZONE_COUNT))
		&& enable_q[items.zone_index]
		&& (items.packet_length >= MIN_PACKET_BYTES);
	assign wr_first_en = in_acc && pkt_ok && !active_q[items.zone_index[ZW-1:0]];

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || results.ready);

	always_comb begin
		tag_kind = TAG_NONE;
		rd_addr  = cnt_q;
		unique case (state_q)
			ST_LOAD: begin
				tag_kind = TAG_INIT;
				rd_addr  = cur_zone_q[ZW-1:0];
			end
			ST_SEL: begin
				tag_kind = TAG_CAND;
			end
			ST_SIL: begin
				tag_kind = TAG_SIL;
			end
			default: begin
				tag_kind = TAG_NONE;
			end
		endcase
	end

	zps_zone_mem #(
		.ZONE_COUNT (ZONE_COUNT),
		.AW         (ZW)
	) u_mem (
		.clk         (clk),
		.wr_last_en  (in_acc && pkt_ok),
		.wr_first_en (wr_first_en),
		.wr_addr     (items.zone_index[ZW-1:0]),
		.wr_data     (items.now_ms),
		.rd_addr     (rd_addr),
		.rd_last     (rd_last),
		.rd_first    (rd_first)
	);

	// candidate compare against the winner so far
	assign cand_zone   = ZONE_W'(tag_zone_s1);
	assign cand_prio   = prio_of(prios_q, cand_zone);
	assign win_prio    = prio_of(prios_q, win_q);
	assign first_diff  = rd_first - win_first_q;
	assign cand_better = !have_q || (cand_prio < win_prio)
		|| ((cand_prio == win_prio) && first_diff[TIME_W-1]);
	assign silent      = active_q[tag_zone_s1] && ((now_q - rd_last) > silence_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			tag_kind_s1 <= TAG_NONE;
			enable_q    <= '0;
			prios_q     <= '0;
			silence_q   <= RESET_SILENCE;
			ssrc_q      <= RESET_SSRC;
			ts_step_q   <= RESET_TS_STEP;
			active_q    <= '0;
			cur_zone_q  <= '0;
			cur_valid_q <= 1'b0;
			next_seq_q  <= '0;
			next_ts_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			tag_kind_s1 <= tag_kind;

			if (cfg_acc) begin
				case (cfg.index)
					CFG_ENABLE: begin
						enable_q <= cfg.data[MASK_W-1:0];
						// leaving zones drop out at once
						active_q <= active_q & cfg.data[ZONE_COUNT-1:0];
					end
					CFG_PRIO:    prios_q   <= cfg.data;
					CFG_SILENCE: silence_q <= cfg.data[TIME_W-1:0];
					CFG_SSRC:    ssrc_q    <= cfg.data[TIME_W-1:0];
					CFG_TS_STEP: ts_step_q <= cfg.data[STEP_W-1:0];
					default: begin
					end
				endcase
			end

			if (in_acc && pkt_ok) begin
				active_q[items.zone_index[ZW-1:0]] <= 1'b1;
			end

			if (tag_kind_s1 == TAG_SIL && silent) begin
				active_q[tag_zone_s1] <= 1'b0;
				if (cur_valid_q && cur_zone_q == cand_zone) begin
					cur_valid_q <= 1'b0;
				end
			end

			if (state_q == ST_DECIDE && have_q && win_q == zi_q) begin
				next_seq_q  <= next_seq_q + SEQ_W'(1);
				next_ts_q   <= next_ts_q + TIME_W'(ts_step_q);
				cur_zone_q  <= win_q;
				cur_valid_q <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						state_q <= pkt_ok ? ST_LOAD : ST_SIL;
					end
				end
				ST_LOAD: begin
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					if (cnt_q == LAST_ZONE) begin
						cnt_q   <= '0;
						state_q <= ST_SDRAIN;
					end else begin
						cnt_q <= cnt_q + ZW'(1);
					end
				end
				ST_SDRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_SIL;
				end
				ST_SIL: begin
					if (cnt_q == LAST_ZONE) begin
						cnt_q   <= '0;
						state_q <= ST_LDRAIN;
					end else begin
						cnt_q <= cnt_q + ZW'(1);
					end
				end
				ST_LDRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		tag_zone_s1 <= rd_addr;

		if (in_acc) begin
			zi_q       <= items.zone_index;
			now_q      <= items.now_ms;
			pt_q       <= items.payload_type;
			fwd_q      <= 1'b0;
			mark_q     <= 1'b0;
			opt_q      <= '0;
			seq_q      <= '0;
			ts_q       <= '0;
			released_q <= '0;
		end

		case (tag_kind_s1)
			TAG_INIT: begin
				// a stale winner starts the pass with no candidate
				have_q <= cur_valid_q
					&& ({1'b0, cur_zone_q} < (ZONE_W+1)'(ZONE_COUNT))
					&& active_q[cur_zone_q[ZW-1:0]];
				win_q       <= cur_zone_q;
				win_first_q <= rd_first;
			end
			TAG_CAND: begin
				if (active_q[tag_zone_s1] && enable_q[cand_zone] && cand_better) begin
					have_q      <= 1'b1;
					win_q       <= cand_zone;
					win_first_q <= rd_first;
				end
			end
			TAG_SIL: begin
				if (silent) begin
					released_q[tag_zone_s1] <= 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (state_q == ST_DECIDE && have_q && win_q == zi_q) begin
			fwd_q  <= 1'b1;
			mark_q <= !cur_valid_q || (cur_zone_q != win_q);
			opt_q  <= pt_q;
			seq_q  <= next_seq_q;
			ts_q   <= next_ts_q;
		end

		if (out_load) begin
			out_fwd_q  <= fwd_q;
			out_mark_q <= mark_q;
			out_pt_q   <= opt_q;
			out_seq_q  <= seq_q;
			out_ts_q   <= ts_q;
			out_wv_q   <= cur_valid_q;
			out_wz_q   <= cur_valid_q ? cur_zone_q : '0;
			out_rel_q  <= MASK_W'(released_q);
		end
	end

	assign results.valid            = out_valid_q;
	assign results.forward          = out_fwd_q;
	assign results.marker           = out_mark_q;
	assign results.out_payload_type = out_pt_q;
	assign results.sequence_number  = out_seq_q;
	assign results.rtp_timestamp    = out_ts_q;
	assign results.winner_valid     = out_wv_q;
	assign results.winner_zone      = out_wz_q;
	assign results.released_mask    = out_rel_q;

endmodule

@@ rtl/zps_checker.sv @@
// ----------------------------------------------------------------------------
// zps_checker
// Port-level checks for the zone priority stream selector, bound to the top.
// ----------------------------------------------------------------------------
module zps_checker import zps_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic              res_forward,
	input logic              res_marker,
	input logic [SEQ_W-1:0]  res_seq,
	input logic [TIME_W-1:0] res_ts,
	input logic              res_wv,
	input logic [ZONE_W-1:0] res_wz
);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_ts) && $stable(res_seq))
		else $error("result beat changed while stalled");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous item in progress");

	// dropped beats carry a clean header
	a_no_fwd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_forward |-> !res_marker && res_seq == '0 && res_ts == '0)
		else $error("header fields set on a dropped beat");

	// no winner means zone reads zero
	a_winner_zone: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_wv |-> res_wz == '0)
		else $error("winner zone set without a winner");

	// a forwarded packet comes from a winner that is still held
	a_fwd_winner: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_forward |-> res_wv)
		else $error("forwarded beat without a current winner");

endmodule

bind zone_priority_stream_selector zps_checker u_zps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (items.valid),
	.in_ready    (items.ready),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.res_forward (results.forward),
	.res_marker  (results.marker),
	.res_seq     (results.sequence_number),
	.res_ts      (results.rtp_timestamp),
	.res_wv      (results.winner_valid),
	.res_wz      (results.winner_zone)
);

@@ bench/tb_zone_priority_stream_selector.sv @@
// ----------------------------------------------------------------------------
// tb_zone_priority_stream_selector
// Self-checking bench: a clocked driver feeds packet and tick beats from a
// backlog, a local selection model predicts every result at accept time, and
// a clocked monitor compares each result beat field by field. Register
// settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_zone_priority_stream_selector import zps_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ZONES       = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 160;

	typedef struct {
		op_t               op;
		logic [ZONE_W-1:0] zone;
		logic [TIME_W-1:0] now;
		logic [LEN_W-1:0]  len;
		logic [PT_W-1:0]   pt;
	} zone_item_t;

	typedef struct {
		logic              forward;
		logic              marker;
		logic [PT_W-1:0]   pt;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] ts;
		logic              win_valid;
		logic [ZONE_W-1:0] win_zone;
		logic [MASK_W-1:0] released;
	} selector_result_t;

	logic clk = 1'b0;
	logic arst_n;

	zps_item_if   item_ch();
	zps_result_if res_ch();
	zps_cfg_if    cfg_ch();

	zone_priority_stream_selector #(.ZONE_COUNT(ZONES)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.items   (item_ch),
		.results (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// local copy of the selector state and registers
	logic [MASK_W-1:0]  en_mask;
	logic [PRIOS_W-1:0] prio_word;
	logic [TIME_W-1:0]  silence_lim;
	logic [TIME_W-1:0]  ssrc_reg;
	logic [STEP_W-1:0]  ts_step;
	logic               zone_on [ZONES];
	logic [TIME_W-1:0]  heard_last [ZONES];
	logic [TIME_W-1:0]  heard_first [ZONES];
	logic [ZONE_W-1:0]  cur_zone;
	logic               cur_valid;
	logic [SEQ_W-1:0]   seq_next;
	logic [TIME_W-1:0]  ts_next;

	zone_item_t       item_backlog[$];
	selector_result_t expected_results[$];
	int               error_count = 0;
	int               cycle_count = 0;

	function automatic void predict_selection(input zone_item_t it, output selector_result_t r);
		logic              have;
		logic [ZONE_W-1:0] win;
		logic [TIME_W-1:0] diff;
		logic [TIME_W-1:0] quiet;
		r = '{default: '0};
		if (it.op == OP_PACKET && en_mask[it.zone] && it.len >= MIN_PACKET_BYTES) begin
			if (!zone_on[it.zone])
				heard_first[it.zone] = it.now;
			heard_last[it.zone] = it.now;
			zone_on[it.zone] = 1'b1;
			// a winner whose zone went inactive is no candidate
			have = cur_valid && zone_on[cur_zone];
			win = cur_zone;
			for (int z = 0; z < ZONES; z++) begin
				if (zone_on[z] && en_mask[z]) begin
					diff = heard_first[z] - heard_first[win];
					if (!have || prio_word[z*PRIO_W +: PRIO_W] < prio_word[win*PRIO_W +: PRIO_W] ||
							(prio_word[z*PRIO_W +: PRIO_W] == prio_word[win*PRIO_W +: PRIO_W] &&
							diff[TIME_W-1])) begin
						have = 1'b1;
						win = ZONE_W'(z);
					end
				end
			end
			if (have && win == it.zone) begin
				r.forward = 1'b1;
				r.marker = !cur_valid || cur_zone != win;
				r.pt = it.pt;
				r.seq = seq_next;
				r.ts = ts_next;
				seq_next = seq_next + 1'b1;
				ts_next = ts_next + {16'd0, ts_step};
				cur_zone = win;
				cur_valid = 1'b1;
			end
		end
		for (int z = 0; z < ZONES; z++) begin
			quiet = it.now - heard_last[z];
			if (zone_on[z] && quiet > silence_lim) begin
				zone_on[z] = 1'b0;
				r.released[z] = 1'b1;
				if (cur_valid && cur_zone == z)
					cur_valid = 1'b0;
			end
		end
		r.win_valid = cur_valid;
		r.win_zone = cur_valid ? cur_zone : '0;
	endfunction

	function automatic void add_item(op_t op, int zone, logic [TIME_W-1:0] now, int len, int pt);
		zone_item_t it;
		it.op = op;
		it.zone = ZONE_W'(zone);
		it.now = now;
		it.len = LEN_W'(len);
		it.pt = PT_W'(pt);
		item_backlog.push_back(it);
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 3)
			return 0;
		else if (roll < 8)
			return $urandom_range(1, 8);
		return $urandom_range(9, 45);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endfunction

	// driver: bursts of beats from the backlog with random gaps between them
	zone_item_t offered;
	logic       offering;
	int         drv_burst;
	int         drv_gap;

	always @(posedge clk or negedge arst_n) begin
		selector_result_t r;
		if (!arst_n) begin
			offering = 1'b0;
			drv_burst = 0;
			drv_gap = 0;
			item_ch.valid <= 1'b0;
		end else begin
			if (offering && item_ch.ready) begin
				predict_selection(offered, r);
				expected_results.push_back(r);
				offering = 1'b0;
			end
			if (!offering) begin
				if (drv_gap > 0) begin
					drv_gap--;
				end else if (item_backlog.size() > 0) begin
					offered = item_backlog.pop_front();
					offering = 1'b1;
					if (drv_burst > 0)
						drv_burst--;
					if (drv_burst == 0) begin
						drv_burst = $urandom_range(1, 12);
						drv_gap = pick_gap();
					end
				end
			end
			item_ch.valid <= offering;
			item_ch.op <= offered.op;
			item_ch.zone_index <= offered.zone;
			item_ch.now_ms <= offered.now;
			item_ch.packet_length <= offered.len;
			item_ch.payload_type <= offered.pt;
		end
	end

	// monitor: checks result beats, stalls on its own pattern, one long hold
	int   results_seen;
	int   hold_left;
	logic hold_done;
	int   stall_mode;
	int   mode_left;

	always @(posedge clk or negedge arst_n) begin
		selector_result_t want;
		logic             rdy;
		if (!arst_n) begin
			results_seen = 0;
			hold_left = 0;
			hold_done = 1'b0;
			stall_mode = 0;
			mode_left = 0;
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result beat with no expected result");
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("forward", 32'(want.forward), 32'(res_ch.forward));
					check_field("marker", 32'(want.marker), 32'(res_ch.marker));
					check_field("out_payload_type", 32'(want.pt),
						32'(res_ch.out_payload_type));
					check_field("sequence_number", 32'(want.seq),
						32'(res_ch.sequence_number));
					check_field("rtp_timestamp", want.ts, res_ch.rtp_timestamp);
					check_field("winner_valid", 32'(want.win_valid), 32'(res_ch.winner_valid));
					check_field("winner_zone", 32'(want.win_zone), 32'(res_ch.winner_zone));
					check_field("released_mask", 32'(want.released), 32'(res_ch.released_mask));
				end
			end
			// long hold so the block fills up and backs up its input
			if (!hold_done && results_seen >= 300) begin
				hold_left = 500;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (stall_mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					default: rdy = ($urandom_range(0, 3) == 0);
				endcase
			end
			res_ch.ready <= rdy;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic wait_idle();
		do
			@(posedge clk);
		while (item_backlog.size() != 0 || offering || expected_results.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_ENABLE: begin
				en_mask = val[MASK_W-1:0];
				for (int z = 0; z < ZONES; z++) begin
					if (!en_mask[z]) begin
						zone_on[z] = 1'b0;
						heard_last[z] = '0;
						heard_first[z] = '0;
					end
				end
			end
			CFG_PRIO:    prio_word = val;
			CFG_SILENCE: silence_lim = val[TIME_W-1:0];
			CFG_SSRC:    ssrc_reg = val[TIME_W-1:0];
			CFG_TS_STEP: ts_step = val[STEP_W-1:0];
			default: ;
		endcase
	endtask

	initial begin
		logic [TIME_W-1:0]  sim_now;
		logic [MASK_W-1:0]  mask_v;
		logic [PRIOS_W-1:0] prio_v;
		logic [TIME_W-1:0]  sil_v;
		logic [TIME_W-1:0]  ssrc_v;
		logic [STEP_W-1:0]  step_v;
		int                 roll;
		int                 zone;
		int                 plen;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_PACKET;
		item_ch.zone_index = '0;
		item_ch.now_ms = '0;
		item_ch.packet_length = '0;
		item_ch.payload_type = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		offered = '{op: OP_PACKET, default: '0};

		en_mask = '0;
		prio_word = '0;
		silence_lim = RESET_SILENCE;
		ssrc_reg = RESET_SSRC;
		ts_step = RESET_TS_STEP;
		for (int z = 0; z < ZONES; z++) begin
			zone_on[z] = 1'b0;
			heard_last[z] = '0;
			heard_first[z] = '0;
		end
		cur_zone = '0;
		cur_valid = 1'b0;
		seq_next = '0;
		ts_next = '0;

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset defaults: every zone disabled, so this packet is dropped
		add_item(OP_PACKET, 2, 32'd50, 100, 10);
		wait_idle();

		// zones 0 and 1 tie, zone 3 is best, zone 15 is worst
		write_register(CFG_ENABLE, 64'hFFFF);
		write_register(CFG_PRIO, 64'hF888_8888_8888_2855);
		add_item(OP_PACKET, 0, 32'd100, 12, 0);
		add_item(OP_PACKET, 0, 32'd110, 11, 5);          // short packet
		add_item(OP_PACKET, 0, 32'd120, 2047, 127);
		add_item(OP_PACKET, 1, 32'd130, 60, 8);          // tie, joined later
		add_item(OP_PACKET, 3, 32'd140, 60, 9);          // lower priority takes over
		add_item(OP_PACKET, 0, 32'd150, 60, 1);
		add_item(OP_TICK, 0, 32'd1200, 0, 0);            // silence releases all three
		add_item(OP_PACKET, 15, 32'd1210, 200, 96);
		add_item(OP_PACKET, 1, 32'd1215, 200, 97);
		add_item(OP_TICK, 15, 32'hFFFF_FFF0, 2047, 127);
		add_item(OP_PACKET, 5, 32'hFFFF_FFF8, 40, 33);
		add_item(OP_PACKET, 6, 32'h0000_0004, 40, 34);  // tie across the time wrap
		add_item(OP_PACKET, 5, 32'h0000_000A, 40, 35);
		add_item(OP_TICK, 7, 32'd500, 1, 64);
		wait_idle();

		// drop the current winner's zone: the stale winner must not count
		write_register(CFG_ENABLE, 64'hFFDF);
		write_register(CFG_TS_STEP, 64'hFFFF);
		write_register(CFG_SSRC, 64'h0);
		write_register(CFG_IDX_W'(CFG_TS_STEP + 3), 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(OP_PACKET, 6, 32'd520, 40, 36);
		add_item(OP_PACKET, 0, 32'd530, 12, 37);
		add_item(OP_PACKET, 0, 32'd540, 13, 38);
		sim_now = 32'd540;

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					mask_v = 16'hFFFF;
					prio_v = '0;
					sil_v = '0;
					step_v = '0;
					ssrc_v = 32'hFFFF_FFFF;
				end
				1: begin
					mask_v = 16'h0001;
					prio_v = '1;
					sil_v = 32'hFFFF_FFFF;
					step_v = 16'hFFFF;
					ssrc_v = '0;
				end
				2: begin
					mask_v = 16'hFFFF;
					prio_v = '1;
					sil_v = RESET_SILENCE;
					step_v = RESET_TS_STEP;
					ssrc_v = RESET_SSRC;
				end
				default: begin
					mask_v = MASK_W'(($urandom_range(0, 3) == 0) ? ($urandom & $urandom)
						: $urandom);
					if (mask_v == '0)
						mask_v = 16'h8000;
					prio_v = {$urandom, $urandom};
					sil_v = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(20, 400);
					step_v = STEP_W'($urandom);
					ssrc_v = $urandom;
				end
			endcase
			write_register(CFG_ENABLE, CFG_DATA_W'(mask_v));
			write_register(CFG_PRIO, prio_v);
			write_register(CFG_SILENCE, CFG_DATA_W'(sil_v));
			write_register(CFG_SSRC, CFG_DATA_W'(ssrc_v));
			write_register(CFG_TS_STEP, CFG_DATA_W'(step_v));
			write_register(CFG_IDX_W'(CFG_TS_STEP + 1 + $urandom_range(0, 2)),
				{$urandom, $urandom});
			if (ph == 4)
				sim_now = 32'hFFFF_F000;
			else if (ph > 4)
				sim_now = $urandom;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 5)
					sim_now += $urandom;
				else if (roll < 20)
					sim_now += $urandom_range(0, 1500);
				else
					sim_now += $urandom_range(0, 25);
				if ($urandom_range(0, 9) == 0) begin
					add_item(OP_TICK, $urandom_range(0, 15), sim_now, $urandom_range(0, 2047),
						$urandom_range(0, 127));
				end else begin
					if ($urandom_range(0, 9) != 0) begin
						do
							zone = $urandom_range(0, 15);
						while (!en_mask[zone]);
					end else begin
						zone = $urandom_range(0, 15);
					end
					if ($urandom_range(0, 9) == 0)
						plen = $urandom_range(0, 11);
					else if ($urandom_range(0, 19) == 0)
						plen = 12;
					else
						plen = $urandom_range(12, 2047);
					add_item(OP_PACKET, zone, sim_now, plen, $urandom_range(0, 127));
				end
			end
		end

		wait_idle();
		repeat (60) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
